[hdl/bpq_pkg.sv]
// bpq_pkg: shared types and codes for the bounded priority queue
// transfer structs, status codes, controller states and datapath commands
// depends on nothing
`default_nettype none

package bpq_pkg;

    // opcode field values
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_REMOVED  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic        opcode;
        logic [31:0] new_plate;
        logic [31:0] new_origin;
        logic [31:0] new_destination;
        logic [15:0] new_priority;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_plate;
        logic [31:0] out_origin;
        logic [31:0] out_destination;
        logic [15:0] out_priority;
        logic [5:0]  occupancy;
    } t_out_item;

    typedef struct packed {
        logic [31:0] plate;
        logic [31:0] origin;
        logic [31:0] destination;
        logic [15:0] priority_key;
    } t_record;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_DROP,
        ACT_REMOVE,
        ACT_EMPTY
    } t_act;

    // controller to datapath
    typedef struct packed {
        logic load;
        t_act act;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

`default_nettype wire

[hdl/bounded_priority_queue_unit.sv]
// bounded_priority_queue_unit: top level of the bounded sorted priority queue
// instantiates bpq_ctrl and bpq_datapath, uses bpq_pkg
//
// Holds up to DEPTH records kept in descending priority order, equal priorities
// oldest first. A request is transferred at a rising edge with start high and
// busy low; opcode insert places the record behind every held record of equal
// or higher priority (or reports full and drops it), opcode remove hands back
// the head record (or reports empty, with zero record fields). Each request gives
// exactly one result on o_out, marked by o_done for exactly one cycle, after the
// execute cycle; the receiver cannot stall and must take it then. A request is
// first transferred into the request register; then, in the execute cycle, on an
// insert every cell of the sorted register row compares its priority with the new
// key and the cells behind the insert point shift in parallel. busy is high only
// in the execute cycle, so the next request may transfer in the cycle its
// predecessor's result is shown. occupancy is the record count modulo 64.
`default_nettype none

module bounded_priority_queue_unit
    import bpq_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_in_item i_in,
    output logic          o_done,
    output t_out_item     o_out
);

    // command and status between sequencer and datapath
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: transfer, execute, result strobe
    bpq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_in.opcode),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    // sorted record row, count and result register
    bpq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (i_in),
        .o_stat  (w_stat),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

[hdl/bpq_datapath.sv]
// bpq_datapath: sorted register row of records, request register and result register
// depends on bpq_pkg
`default_nettype none

module bpq_datapath
    import bpq_pkg::*;
#(
    parameter int DEPTH = 32,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_dp_cmd   i_cmd,
    input  wire t_in_item  i_item,
    output t_dp_stat       o_stat,
    output t_out_item      o_out
);

    t_in_item        r_item;
    t_record         r_rec [DEPTH];
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    t_out_item       r_out;

    t_record         w_new;
    logic [DEPTH-1:0] w_ge;
    logic [DEPTH-1:0] w_take;
    t_record         w_shift_in [DEPTH];

    assign w_new = '{plate:        r_item.new_plate,
                     origin:       r_item.new_origin,
                     destination:  r_item.new_destination,
                     priority_key: r_item.new_priority};

    // per cell: held and at least as urgent as the new record
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_ge[i] = (CW'(i) < r_count) && (r_rec[i].priority_key >= r_item.new_priority);
        end
    end

    // first cell past the prefix of ge cells takes the new record
    assign w_take = {w_ge[DEPTH-2:0], 1'b1};

    always_comb begin
        w_shift_in[0] = w_new;
        for (int i = 1; i < DEPTH; i++) begin
            w_shift_in[i] = r_rec[i-1];
        end
    end

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        unique case (i_cmd.act)
            ACT_INSERT: n_count = r_count + CW'(1);
            ACT_REMOVE: n_count = r_count - CW'(1);
            default:    n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        unique case (i_cmd.act)
            ACT_INSERT: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (!w_ge[i]) begin
                        r_rec[i] <= w_take[i] ? w_new : w_shift_in[i];
                    end
                end
            end
            ACT_REMOVE: begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                    r_rec[i] <= r_rec[i+1];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.act)
            ACT_INSERT, ACT_DROP, ACT_EMPTY: begin
                r_out.status          <= (i_cmd.act == ACT_INSERT) ? ST_INSERTED :
                                         (i_cmd.act == ACT_DROP) ? ST_FULL : ST_EMPTY;
                r_out.out_plate       <= '0;
                r_out.out_origin      <= '0;
                r_out.out_destination <= '0;
                r_out.out_priority    <= '0;
                r_out.occupancy       <= 6'(n_count);
            end
            ACT_REMOVE: begin
                r_out.status          <= ST_REMOVED;
                r_out.out_plate       <= r_rec[0].plate;
                r_out.out_origin      <= r_rec[0].origin;
                r_out.out_destination <= r_rec[0].destination;
                r_out.out_priority    <= r_rec[0].priority_key;
                r_out.occupancy       <= 6'(n_count);
            end
            default: begin
            end
        endcase
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

[hdl/bpq_ctrl.sv]
// bpq_ctrl: request sequencer for the bounded priority queue
// depends on bpq_pkg
`default_nettype none

module bpq_ctrl
    import bpq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire logic     i_opcode,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_busy,
    output logic          o_done
);

    t_state r_state;
    t_state n_state;
    logic   r_opcode;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_EXEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd.load) begin
            r_opcode <= i_opcode;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.act  = ACT_NONE;
        o_busy     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_busy = 1'b1;
                if (r_opcode == OP_INSERT) begin
                    o_cmd.act = i_stat.full ? ACT_DROP : ACT_INSERT;
                end else begin
                    o_cmd.act = i_stat.empty ? ACT_EMPTY : ACT_REMOVE;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

[hdl/bpq_checker.sv]
// bpq_checker: port level checks of the bounded priority queue, with its bind
// depends on bpq_pkg and bounded_priority_queue_unit
`default_nettype none

module bpq_checker
    import bpq_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      o_done,
    input wire t_out_item o_out
);

    // a transfer is followed by its result strobe
    a_done_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("result strobe missing after request transfer");

    // a result cycle always lets the next request in
    a_not_busy_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("busy while result shown");

    // no two result strobes back to back
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // an empty report carries no record and no occupancy
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.status == ST_EMPTY) |->
            (o_out.occupancy == '0 && o_out.out_plate == '0 && o_out.out_priority == '0))
        else $error("empty result with nonzero fields");

endmodule

bind bounded_priority_queue_unit bpq_checker u_bpq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_out   (o_out)
);

`default_nettype wire
